// ----- hw/rtl/rsrs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsrs_pkg
// Shared types and codes of the random subset reduction search block.
// ----------------------------------------------------------------------------
package rsrs_pkg;

    // Default size of the line block under search.
    localparam int MAX_LINES_DEF = 64;

    // Fixed field widths of the words on the channels and the registers.
    localparam int OPCODE_W = 2;
    localparam int RAND_W   = 16;
    localparam int DELTA_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LINE_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int MASK_W   = 64;
    localparam int ALEN_W   = 7;
    localparam int ITER_W   = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Opcodes of an input word.
    localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PICK    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_VERDICT = 2'd2;

    // Status codes of a result word.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LONE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ENDED    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT   = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic [RAND_W-1:0]         random_value;
        logic signed [DELTA_W-1:0] latency_delta;
    } t_req_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LINE_W-1:0]   line_index;
        logic                removing;
        logic [COUNT_W-1:0]  member_count;
        logic [COUNT_W-1:0]  best_count;
        logic [MASK_W-1:0]   current_set;
        logic [MASK_W-1:0]   best_set;
    } t_rsp_word;

endpackage
`default_nettype wire

// ----- hw/rtl/rsrs_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsrs_in_if
// Valid/ready channel that carries request words into the search block.
// ----------------------------------------------------------------------------
interface rsrs_in_if
    import rsrs_pkg::*;
();
    logic      valid;
    logic      ready;
    t_req_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rsrs_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsrs_out_if
// Valid/ready channel that carries result words out of the search block.
// ----------------------------------------------------------------------------
interface rsrs_out_if
    import rsrs_pkg::*;
();
    logic      valid;
    logic      ready;
    t_rsp_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rsrs_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsrs_div
// Iterative restoring divider that returns the remainder, one bit a cycle.
// ----------------------------------------------------------------------------
module rsrs_div
    import rsrs_pkg::*;
#(
    parameter int DIVIDEND_W = RAND_W,
    parameter int DIVISOR_W  = $clog2(MAX_LINES_DEF + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [DIVISOR_W-1:0]       o_remainder
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0] shifted;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    // The partial remainder stays below the divisor, so one more bit fits
    // the shifted value.
    assign shifted = {r_rem, r_quo[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(DIVIDEND_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b0};
                r_rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

// ----- hw/rtl/random_subset_reduction_search.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// random_subset_reduction_search
// Heuristic reduction of a subset of lines held as bitmasks.
// ----------------------------------------------------------------------------
// The block takes one word at a time and is not ready while it works on it.
// A restart or a verdict goes from its acceptance to S_DONE, which loads the
// result register before the next word is accepted. A verdict that finds a
// single line left first walks the mask for the lowest member. A pick is the
// long case: a remainder of the random value by the active length L, a walk
// over the L lines to count the candidates, a second remainder by that count
// and a circular walk from line 1 to the chosen candidate. Each remainder
// takes 16 divider steps and a hand-over of the result. Both remainders
// run on one shared bit-serial divider, and the walks read one mask bit a
// cycle. The result sits in an output register, so the next word is
// accepted while the previous result still waits to be taken.
// Configuration writes are taken at any time but must only be made while
// the block is idle.
// ----------------------------------------------------------------------------
module random_subset_reduction_search
    import rsrs_pkg::*;
#(
    parameter int MAX_LINES = MAX_LINES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    rsrs_in_if.sink                    i_req,
    rsrs_out_if.source                 o_rsp
);

    // Width of a line count up to MAX_LINES and of a line index.
    localparam int LW = $clog2(MAX_LINES + 1);
    localparam int IW = $clog2(MAX_LINES);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_LINES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD_LEN,
        S_COUNT,
        S_MOD_CNT,
        S_FIND,
        S_LONE,
        S_DONE
    } t_state;

    // Configuration registers.
    logic [ALEN_W-1:0]         r_active_length;
    logic signed [DELTA_W-1:0] r_threshold;
    logic [ITER_W-1:0]         r_iter_limit;

    // Search state.
    logic [MAX_LINES-1:0] r_cur;
    logic [MAX_LINES-1:0] r_best;
    logic                 r_remove;
    logic [COUNT_W-1:0]   r_member;
    logic [COUNT_W-1:0]   r_best_total;
    logic [IW-1:0]        r_last;
    logic [ITER_W-1:0]    r_vcount;
    logic                 r_over;

    // Sequencer and work registers.
    t_state        r_state;
    logic [IW-1:0] r_idx;
    logic [LW-1:0] r_cnt;
    logic [LW-1:0] r_rnd;
    logic [LW-1:0] r_k;
    logic [STATUS_W-1:0] r_status;
    logic [IW-1:0] r_line;
    logic          r_out_valid;
    t_rsp_word     r_out_data;

    logic                 in_acc;
    logic [LW-1:0]        len;
    logic [IW-1:0]        len_last;
    logic [MAX_LINES-1:0] full_mask;
    logic                 cur_bit;
    logic                 hit;
    logic                 idx_last;
    logic [IW-1:0]        idx_next;
    logic [LW-1:0]        match_total;

    logic                 v_gt;
    logic                 v_lone;
    logic                 v_improve;
    logic                 v_end;
    logic                 n_remove;
    logic [ITER_W-1:0]    n_vcount;

    logic              div_start;
    logic [RAND_W-1:0] div_dividend;
    logic [LW-1:0]     div_divisor;
    logic              div_done;
    logic [LW-1:0]     div_rem;

    assign in_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // A length of zero acts as one line, and one above MAX_LINES is clipped.
    always_comb begin
        if (r_active_length == '0) begin
            len = LW'(1);
        end else if (r_active_length > ALEN_W'(MAX_LINES)) begin
            len = LW'(MAX_LINES);
        end else begin
            len = LW'(r_active_length);
        end
    end

    assign len_last = IW'(len - LW'(1));

    always_comb begin
        for (int i = 0; i < MAX_LINES; i++) begin
            full_mask[i] = (i < int'(len));
        end
    end

    // One mask bit is examined per cycle during the walks.
    assign cur_bit     = r_cur[r_idx];
    assign hit         = (cur_bit == r_remove);
    assign idx_last    = (r_idx == len_last);
    assign idx_next    = idx_last ? '0 : r_idx + IW'(1);
    assign match_total = r_cnt + LW'(hit);

    // Verdict decisions, all taken in the cycle the word is accepted.
    assign v_gt      = ($signed(i_req.data.latency_delta) > r_threshold);
    assign v_lone    = v_gt && (r_member == COUNT_W'(1));
    assign v_improve = !v_gt && ((r_member + COUNT_W'(1)) < r_best_total);
    assign n_vcount  = r_vcount + ITER_W'(1);
    assign v_end     = (n_vcount >= r_iter_limit);
    assign n_remove  = v_gt || (r_member == COUNT_W'(len));

    // The divider is shared by the two remainders of a pick.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = i_req.data.random_value;
        div_divisor  = len;
        if (r_state == S_IDLE && in_acc && i_req.data.opcode == OP_PICK && !r_over) begin
            div_start = 1'b1;
        end else if (r_state == S_COUNT && idx_last && match_total != '0) begin
            div_start    = 1'b1;
            div_dividend = RAND_W'(r_rnd);
            div_divisor  = match_total;
        end
    end

    rsrs_div #(
        .DIVIDEND_W (RAND_W),
        .DIVISOR_W  (LW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_length <= ALEN_W'(64);
            r_threshold     <= DELTA_W'(100);
            r_iter_limit    <= ITER_W'(1000);
            r_cur           <= '1;
            r_best          <= '1;
            r_remove        <= 1'b1;
            r_member        <= COUNT_W'(MAX_LINES);
            r_best_total    <= COUNT_W'(MAX_LINES);
            r_last          <= '0;
            r_vcount        <= '0;
            r_over          <= 1'b0;
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_idx           <= '0;
            r_cnt           <= '0;
            r_status        <= ST_OK;
            r_line          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ACTIVE_LENGTH:     r_active_length <= i_cfg_data[ALEN_W-1:0];
                    CFG_SUCCESS_THRESHOLD: r_threshold     <= i_cfg_data[DELTA_W-1:0];
                    CFG_ITERATION_LIMIT:   r_iter_limit    <= i_cfg_data[ITER_W-1:0];
                    default: ;
                endcase
            end

            if (o_rsp.valid && o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_status <= ST_OK;
                        r_line   <= '0;
                        r_state  <= S_DONE;
                        unique case (i_req.data.opcode)
                            OP_RESTART: begin
                                r_cur        <= full_mask;
                                r_best       <= full_mask;
                                r_remove     <= 1'b1;
                                r_member     <= COUNT_W'(len);
                                r_best_total <= COUNT_W'(len);
                                r_last       <= '0;
                                r_vcount     <= '0;
                                r_over       <= 1'b0;
                            end
                            OP_PICK: begin
                                if (r_over) begin
                                    r_status <= ST_ENDED;
                                end else begin
                                    r_state <= S_MOD_LEN;
                                end
                            end
                            OP_VERDICT: begin
                                if (r_over) begin
                                    r_status <= ST_ENDED;
                                end else if (v_lone) begin
                                    // One line left: report the lowest member.
                                    r_remove <= 1'b1;
                                    r_over   <= 1'b1;
                                    r_status <= ST_LONE;
                                    r_idx    <= '0;
                                    r_state  <= S_LONE;
                                end else begin
                                    r_remove <= n_remove;
                                    if (v_improve) begin
                                        r_best <= r_cur | (MAX_LINES'(1) << r_last);
                                        r_best_total <= r_member + COUNT_W'(1);
                                    end
                                    r_vcount <= n_vcount;
                                    if (v_end) begin
                                        r_over   <= 1'b1;
                                        r_status <= ST_ENDED;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MOD_LEN: begin
                    if (div_done) begin
                        r_rnd   <= div_rem;
                        r_idx   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    if (idx_last) begin
                        if (match_total == '0) begin
                            r_status <= ST_NO_MATCH;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_MOD_CNT;
                        end
                    end else begin
                        r_cnt <= match_total;
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_MOD_CNT: begin
                    if (div_done) begin
                        r_k     <= div_rem;
                        r_idx   <= (len == LW'(1)) ? '0 : IW'(1);
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (hit && r_k == '0) begin
                        r_cur[r_idx] <= ~cur_bit;
                        r_member <= r_remove ? r_member - COUNT_W'(1)
                                             : r_member + COUNT_W'(1);
                        r_last   <= r_idx;
                        r_line   <= r_idx;
                        r_state  <= S_DONE;
                    end else begin
                        if (hit) begin
                            r_k <= r_k - LW'(1);
                        end
                        r_idx <= idx_next;
                    end
                end
                S_LONE: begin
                    if (cur_bit) begin
                        r_line  <= r_idx;
                        r_state <= S_DONE;
                    end else if (r_idx == LAST_IDX) begin
                        // An empty mask reports line zero.
                        r_line  <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid             <= 1'b1;
                        r_out_data.status       <= r_status;
                        r_out_data.line_index   <= LINE_W'(r_line);
                        r_out_data.removing     <= r_remove;
                        r_out_data.member_count <= r_member;
                        r_out_data.best_count   <= r_best_total;
                        r_out_data.current_set  <= MASK_W'(r_cur);
                        r_out_data.best_set     <= MASK_W'(r_best);
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

    // A result word only appears after the sequencer has finished a word.
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state == S_DONE))
        else $error("result word raised outside the finishing state");

    // Taking a line always moves the member count by one.
    a_pick_moves_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND && hit && r_k == '0) |=> (r_member != $past(r_member)))
        else $error("pick did not change the member count");

    // Both line walks stay inside the active lines.
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND || r_state == S_COUNT) |-> (LW'(r_idx) < len))
        else $error("line walk left the active lines");

    // The member count never exceeds the block size when a word finishes.
    a_member_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_member <= COUNT_W'(MAX_LINES)))
        else $error("member count above the number of lines");

endmodule
`default_nettype wire
